FILE: hw/rtl/hwb_pkg.sv
// Shared constants, types and the quarter-wave sine table of the wavetable builder.
package hwb_pkg;

  localparam int TABLE_LEN     = 1024;
  localparam int MAX_HARMONICS = 64;
  localparam int ENTRY_W       = $clog2(TABLE_LEN);
  localparam int HARM_W        = $clog2(MAX_HARMONICS);
  localparam int QUARTER       = TABLE_LEN / 4;
  localparam int ROM_W         = ENTRY_W - 1;
  localparam int CNT_W         = 7;
  localparam int INDEX_W       = 11;
  localparam int SAMPLE_W      = 16;
  localparam int ACC_W         = 38;
  localparam int PROD_W        = 2 * SAMPLE_W;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic signed [ACC_W-1:0]    ONE_Q30  = ACC_W'(64'd1 << 30);
  localparam logic signed [SAMPLE_W-1:0] AMP_ONE  = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SAT_POS  = 16'sd32767;

  typedef logic [SAMPLE_W-2:0] quarter_rom_t [QUARTER+1];

  typedef struct packed {
    logic               amp_we;
    logic [HARM_W-1:0]  amp_addr;
    logic [ENTRY_W-1:0] rd_addr;
    logic               resp_set;
    logic               resp_status;
    logic               resp_take_rd;
    logic               out_load;
    logic               peak_init;
    logic               mac_valid;
    logic               mac_first;
    logic               mac_last;
    logic               mac_zero;
    logic [HARM_W-1:0]  mac_n;
    logic [ENTRY_W-1:0] entry;
    logic               div_start;
    logic               norm_wr;
  } ctl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_busy;
    logic build_wr;
  } dp_status_t;

  // Taylor series to x^11 in Q2.30, evaluated once at elaboration
  function automatic quarter_rom_t build_quarter();
    quarter_rom_t rom;
    longint unsigned p;
    longint unsigned th;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned s;
    longint unsigned v;
    longint unsigned one;
    one = 64'd1 << 30;
    for (int k = 0; k <= QUARTER; k++) begin
      p  = (longint'(k) << 32) / TABLE_LEN;
      th = (p * 64'd3373259426) >> 31;
      x2 = (th * th) >> 30;
      r  = one;
      r  = one - ((x2 * r) >> 30) / 110;
      r  = one - ((x2 * r) >> 30) / 72;
      r  = one - ((x2 * r) >> 30) / 42;
      r  = one - ((x2 * r) >> 30) / 20;
      r  = one - ((x2 * r) >> 30) / 6;
      s  = (th * r) >> 30;
      v  = (s + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      rom[k] = v[SAMPLE_W-2:0];
    end
    return rom;
  endfunction

  localparam quarter_rom_t SINE_QUARTER = build_quarter();

endpackage

FILE: hw/rtl/hwb_div.sv
// Sequential restoring divider: saturated Q1.15 quotient of sum / peak.
module hwb_div import hwb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [ACC_W-1:0]    dividend,
  input  logic signed [ACC_W-1:0]    divisor,
  output logic                       busy,
  output logic signed [SAMPLE_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SAMPLE_W);

  logic [ACC_W:0]          rem;
  logic [ACC_W-1:0]        dmag;
  logic [SAMPLE_W-1:0]     qmag;
  logic [STEP_W-1:0]       step;
  logic                    neg;
  logic [ACC_W:0]          rs;
  logic [ACC_W:0]          diff;
  logic                    qbit;

  function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : v;
  endfunction

  // first step weighs 2^15 without a shift; |dividend| <= |divisor| always
  assign rs   = (step == '0) ? rem : {rem[ACC_W-1:0], 1'b0};
  assign diff = rs - {1'b0, dmag};
  assign qbit = (rs >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_W'(SAMPLE_W - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, mag(dividend)};
      dmag <= mag(divisor);
      neg  <= dividend[ACC_W-1] ^ divisor[ACC_W-1];
      qmag <= '0;
    end else if (busy) begin
      rem  <= qbit ? diff : rs;
      qmag <= {qmag[SAMPLE_W-2:0], qbit};
    end
  end

  always_comb begin
    if (neg) quotient = $signed(SAMPLE_W'(-{1'b0, qmag}));
    else if (qmag[SAMPLE_W-1]) quotient = SAT_POS;
    else quotient = $signed(qmag);
  end

endmodule

FILE: hw/rtl/hwb_ctrl.sv
// Sequencer: decodes transactions and walks the build and normalize passes.
module hwb_ctrl import hwb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [INDEX_W-1:0] index,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               cfg_write_en,
  input  logic [CNT_W-1:0]   cfg_write_data,
  input  dp_status_t         st,
  output ctl_cmd_t           cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_RESP   = 3'd2;
  localparam logic [2:0] S_BISSUE = 3'd3;
  localparam logic [2:0] S_BDRAIN = 3'd4;
  localparam logic [2:0] S_NREAD  = 3'd5;
  localparam logic [2:0] S_NLOAD  = 3'd6;
  localparam logic [2:0] S_NDIV   = 3'd7;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   eff;
  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] entry_next;
  logic [HARM_W-1:0]  n;
  logic [HARM_W-1:0]  n_next;
  logic               last_h;
  logic               last_e;
  logic               accept;
  logic               slot_free;

  assign eff       = (count > CNT_W'(MAX_HARMONICS)) ? CNT_W'(MAX_HARMONICS) : count;
  assign last_h    = (eff == '0) || (CNT_W'(n) == eff - CNT_W'(1));
  assign last_e    = (entry == ENTRY_W'(TABLE_LEN - 1));
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    entry_next     = entry;
    n_next         = n;
    cmd.amp_addr   = index[HARM_W-1:0];
    cmd.mac_n      = n;
    cmd.entry      = entry;
    cmd.mac_first  = (n == '0);
    cmd.mac_last   = last_h;
    cmd.mac_zero   = (eff == '0);
    // index TABLE_LEN aliases entry 0 through the dropped top bit
    cmd.rd_addr    = (state == S_IDLE) ? index[ENTRY_W-1:0] : entry;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.resp_set = 1'b1;
          case (mode)
            MODE_WRITE: begin
              cmd.resp_status = (index >= INDEX_W'(MAX_HARMONICS));
              cmd.amp_we      = !cmd.resp_status;
              state_next      = S_RESP;
            end
            MODE_BUILD: begin
              cmd.peak_init = 1'b1;
              entry_next    = '0;
              n_next        = '0;
              state_next    = S_BISSUE;
            end
            MODE_READ: begin
              cmd.resp_status = (index > INDEX_W'(TABLE_LEN));
              state_next      = cmd.resp_status ? S_RESP : S_RDWAIT;
            end
            default: begin
              cmd.resp_status = 1'b1;
              state_next      = S_RESP;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        cmd.resp_take_rd = 1'b1;
        state_next       = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_BISSUE: begin
        cmd.mac_valid = 1'b1;
        if (last_h) begin
          n_next     = '0;
          entry_next = entry + ENTRY_W'(1);
          if (last_e) state_next = S_BDRAIN;
        end else begin
          n_next = n + HARM_W'(1);
        end
      end
      S_BDRAIN: begin
        if (!st.pipe_busy) state_next = S_NREAD;
      end
      S_NREAD: state_next = S_NLOAD;
      S_NLOAD: begin
        cmd.div_start = 1'b1;
        state_next    = S_NDIV;
      end
      S_NDIV: begin
        if (!st.div_busy) begin
          cmd.norm_wr = 1'b1;
          entry_next  = entry + ENTRY_W'(1);
          state_next  = last_e ? S_RESP : S_NREAD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= CNT_W'(1);
      entry     <= '0;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      entry <= entry_next;
      n     <= n_next;
      if (cfg_write_en) count <= cfg_write_data;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/hwb_dp.sv
// Datapath: amplitude and table memories, sine lookup, MAC pipeline, peak, normalize.
module hwb_dp import hwb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  ctl_cmd_t                   cmd,
  input  logic signed [SAMPLE_W-1:0] amplitude,
  output dp_status_t                 st,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       status
);

  logic signed [SAMPLE_W-1:0] amp_mem [MAX_HARMONICS];
  logic [MAX_HARMONICS-1:0]   amp_valid;
  logic [ACC_W-1:0]           table_mem [TABLE_LEN];
  logic [ACC_W-1:0]           rd_q;

  logic [ENTRY_W-1:0] phase;
  logic [ENTRY_W-1:0] ph_cur;
  logic [ROM_W-1:0]   rom_addr;

  // stage 2: memory and ROM outputs
  logic                       v2, f2, l2, z2, neg2, aok2, a02;
  logic [ENTRY_W-1:0]         i2;
  logic [SAMPLE_W-2:0]        rom2;
  logic signed [SAMPLE_W-1:0] amp_q2;
  logic signed [SAMPLE_W-1:0] sine2;
  logic signed [SAMPLE_W-1:0] amp2;
  // stage 3: product
  logic                       v3, f3, l3;
  logic [ENTRY_W-1:0]         i3;
  logic signed [PROD_W-1:0]   prod3;

  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_new;
  logic signed [ACC_W-1:0]    peak;
  logic signed [SAMPLE_W-1:0] resp_sample;
  logic                       resp_status;
  logic signed [SAMPLE_W-1:0] quotient;
  logic                       div_busy;

  logic                       tbl_we;
  logic [ENTRY_W-1:0]         tbl_waddr;
  logic [ACC_W-1:0]           tbl_wdata;

  function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : v;
  endfunction

  // phase of harmonic n+1 at entry i, stepped by i each harmonic
  assign ph_cur   = cmd.mac_first ? cmd.entry : phase + cmd.entry;
  assign rom_addr = ph_cur[ENTRY_W-2] ? ROM_W'(QUARTER) - ROM_W'(ph_cur[ENTRY_W-3:0])
                                      : ROM_W'(ph_cur[ENTRY_W-3:0]);

  always_ff @(posedge clk) begin
    if (cmd.mac_valid) phase <= ph_cur;
    rom2   <= SINE_QUARTER[rom_addr];
    neg2   <= ph_cur[ENTRY_W-1];
    amp_q2 <= amp_mem[cmd.mac_n];
    aok2   <= amp_valid[cmd.mac_n];
    a02    <= (cmd.mac_n == '0);
    f2     <= cmd.mac_first;
    l2     <= cmd.mac_last;
    z2     <= cmd.mac_zero;
    i2     <= cmd.entry;
    if (cmd.amp_we) amp_mem[cmd.amp_addr] <= amplitude;
  end

  always_ff @(posedge clk) begin
    if (rst) amp_valid <= '0;
    else if (cmd.amp_we) amp_valid[cmd.amp_addr] <= 1'b1;
  end

  // unwritten amplitude entries read as AMP_ONE for harmonic 0 and zero for the rest
  always_comb begin
    sine2 = neg2 ? -$signed({1'b0, rom2}) : $signed({1'b0, rom2});
    if (z2) amp2 = '0;
    else if (aok2) amp2 = amp_q2;
    else if (a02) amp2 = AMP_ONE;
    else amp2 = '0;
  end

  always_ff @(posedge clk) begin
    prod3 <= amp2 * sine2;
    f3    <= f2;
    l3    <= l2;
    i3    <= i2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= cmd.mac_valid;
      v3 <= v2;
    end
  end

  assign acc_new = (f3 ? ACC_W'(0) : acc) + ACC_W'(prod3);

  always_ff @(posedge clk) begin
    if (v3) acc <= acc_new;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.peak_init) peak <= ONE_Q30;
    else if (st.build_wr && (mag(peak) < mag(acc_new))) peak <= acc_new;
  end

  assign tbl_we    = st.build_wr || cmd.norm_wr;
  assign tbl_waddr = st.build_wr ? i3 : cmd.entry;
  assign tbl_wdata = st.build_wr ? acc_new : ACC_W'(quotient);

  always_ff @(posedge clk) begin
    if (tbl_we) table_mem[tbl_waddr] <= tbl_wdata;
    rd_q <= table_mem[cmd.rd_addr];
  end

  hwb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ($signed(rd_q)),
    .divisor  (peak),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.resp_set) begin
      resp_sample <= '0;
      resp_status <= cmd.resp_status;
    end else if (cmd.resp_take_rd) begin
      resp_sample <= $signed(rd_q[SAMPLE_W-1:0]);
    end
    if (cmd.out_load) begin
      sample <= resp_sample;
      status <= resp_status;
    end
  end

  assign st.pipe_busy = v2 || v3;
  assign st.div_busy  = div_busy;
  assign st.build_wr  = v3 && l3;

endmodule

FILE: hw/rtl/harmonic_wavetable_builder.sv
// Top level of the additive harmonic wavetable builder.
//
//  channel | direction | handshake           | payload
//  input   | in        | in_valid / in_stall | mode, index, amplitude
//  output  | out       | out_valid/out_stall | sample, status
//  config  | in        | cfg_write_en        | cfg_write_data (harmonic_count)
//
// One transaction at a time. Amplitude writes and errors go straight to the response state,
// a table read passes a wait state first (registered table memory read).
// Build: TABLE_LEN*min(max(count,1),64) MAC issues and a drain of the MAC pipeline, then
// a normalize pass (read, divider load, 16-step divide, write back per entry).
// Synchronous reset clears control and amplitude valid bits, sets count to 1 and peak to ONE_Q30; no clearing pass.
// A stalled result holds in the output register while the next transaction is taken.
module harmonic_wavetable_builder import hwb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 mode,
  input  logic [INDEX_W-1:0]         index,
  input  logic signed [SAMPLE_W-1:0] amplitude,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       status,
  input  logic                       cfg_write_en,
  input  logic [CNT_W-1:0]           cfg_write_data
);

  ctl_cmd_t   cmd;
  dp_status_t st;

  hwb_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .index          (index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .st             (st),
    .cmd            (cmd)
  );

  hwb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .amplitude (amplitude),
    .st        (st),
    .sample    (sample),
    .status    (status)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken while one is in flight");

  a_pipe_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    st.pipe_busy |-> in_stall)
    else $error("MAC pipeline active while idle");

  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    !(st.build_wr && cmd.norm_wr))
    else $error("build and normalize write the table together");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (!st.div_busy && !st.pipe_busy))
    else $error("divider started while busy");
`endif

endmodule
